>>> rtl/adq_pkg.sv
// ----------------------------------------------------------------------------
// Array deque package
// Shared types, codes and defaults for the array double-ended queue.
// ----------------------------------------------------------------------------
package adq_pkg;

   // Default store depth and word width
   localparam int unsigned DEPTH_DEF = 16;
   localparam int unsigned WORD_W    = 32;

   // Stream payload widths, padded to whole bytes
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 40;

   // Operation codes
   typedef enum logic [1:0] {
      CMD_PUSH_REAR  = 2'd0,
      CMD_PUSH_FRONT = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } cmd_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NO_FRONT = 2'd3
   } status_type;

   // Controller states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_LOAD = 1'b1
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;   // take the request transaction, update marks and store
      logic load;     // load the result register
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic rsp_full; // result register holds an untaken transaction
   } dp_status_type;

endpackage

>>> rtl/adq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module adq_ram #(
   parameter  int unsigned WIDTH  = 32,
   parameter  int unsigned DEPTH  = 16,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/adq_ctrl.sv
// ----------------------------------------------------------------------------
// Array deque controller
// Sequences one transaction at a time: accept, then load the result.
// ----------------------------------------------------------------------------
module adq_ctrl
   import adq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type dp_status,
   output logic          req_tready,
   output ctrl_cmd_type  ctrl_cmd
);

   state_type state_ff;
   state_type state_in;
   logic      ready;

   // Take a request only when the result register is free by the load cycle
   assign ready = (state_ff == S_IDLE) && (!dp_status.rsp_full || rsp_tready);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_tready      = 1'b0;
      ctrl_cmd.accept = 1'b0;
      ctrl_cmd.load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready      = ready;
            ctrl_cmd.accept = req_tvalid && ready;
         end
         S_LOAD: begin
            ctrl_cmd.load = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/adq_dp.sv
// ----------------------------------------------------------------------------
// Array deque datapath
// Front and rear marks, word store, operation decode and result register.
// ----------------------------------------------------------------------------
module adq_dp
   import adq_pkg::*;
#(
   parameter  int unsigned DEPTH  = DEPTH_DEF,
   localparam int unsigned MARK_W = $clog2(DEPTH + 1),
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          ctrl_cmd,
   output dp_status_type         dp_status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [MARK_W-1:0] MarkTop = MARK_W'(DEPTH);
   localparam logic [MARK_W-1:0] MarkOne = MARK_W'(1);

   // Marks, held as offsets (mark + 1)
   logic [MARK_W-1:0] front_ff, front_in;
   logic [MARK_W-1:0] rear_ff,  rear_in;

   // Operation stage, waits for the store read
   logic              pop_ok_ff;
   status_type        status_ff;
   logic              empty_ff;
   logic              full_ff;

   // Result register
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] pop_value_ff;
   status_type        rsp_status_ff;
   logic              rsp_empty_ff;
   logic              rsp_full_ff;

   // Decode and store access
   cmd_type           cmd;
   logic [WORD_W-1:0] push_value;
   logic              is_empty;
   logic              pop_ok;
   status_type        status;
   logic              wr_en;
   logic [MARK_W-1:0] wr_mark;
   logic [MARK_W-1:0] rd_mark;
   logic [WORD_W-1:0] rd_data;

   assign cmd        = cmd_type'(req_tdata[1:0]);
   assign push_value = req_tdata[WORD_W+1:2];
   assign is_empty   = (front_ff == rear_ff);

   // Decode the operation and work out the next marks
   always_comb begin
      front_in = front_ff;
      rear_in  = rear_ff;
      status   = ST_OK;
      pop_ok   = 1'b0;
      wr_en    = 1'b0;
      wr_mark  = rear_ff;
      rd_mark  = front_ff;
      unique case (cmd)
         CMD_PUSH_REAR: begin
            if (rear_ff == MarkTop) begin
               status = ST_FULL;
            end else begin
               wr_en   = 1'b1;
               wr_mark = rear_ff;
               rear_in = rear_ff + MarkOne;
            end
         end
         CMD_PUSH_FRONT: begin
            if (front_ff == '0) begin
               status = ST_NO_FRONT;
            end else begin
               wr_en    = 1'b1;
               wr_mark  = front_ff - MarkOne;
               front_in = front_ff - MarkOne;
            end
         end
         CMD_POP_FRONT: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               pop_ok   = 1'b1;
               rd_mark  = front_ff;
               front_in = front_ff + MarkOne;
            end
         end
         CMD_POP_REAR: begin
            if (is_empty || rear_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               pop_ok  = 1'b1;
               rd_mark = rear_ff - MarkOne;
               rear_in = rear_ff - MarkOne;
            end
         end
         default: begin
            status = ST_EMPTY;
         end
      endcase
   end

   // Word store
   adq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl_cmd.accept && wr_en),
      .wr_addr (wr_mark[ADDR_W-1:0]),
      .wr_data (push_value),
      .rd_addr (rd_mark[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Advance the marks on an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
      end else if (ctrl_cmd.accept) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
      end
   end

   // Hold the operation outcome while the store read completes
   always_ff @(posedge clock) begin
      if (ctrl_cmd.accept) begin
         pop_ok_ff <= pop_ok;
         status_ff <= status;
         empty_ff  <= (front_in == rear_in);
         full_ff   <= (rear_in == MarkTop);
      end
   end

   // Result valid: set on load, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         pop_value_ff  <= pop_ok_ff ? rd_data : '1;
         rsp_status_ff <= status_ff;
         rsp_empty_ff  <= empty_ff;
         rsp_full_ff   <= full_ff;
      end
   end

   assign dp_status.rsp_full = rsp_valid_ff;
   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_tdata          = {(RSP_DATA_W - WORD_W - 4)'(0), rsp_full_ff, rsp_empty_ff,
                                rsp_status_ff, pop_value_ff};

endmodule

>>> rtl/array_double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// Array double-ended queue
// Linear deque of signed words with front and rear push and pop.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one operation per transaction: push at rear,
//   push at front, pop at front or pop at rear, with the word to push.
//   The rsp_ channel returns exactly one result per operation: the popped
//   word (all ones on pushes and refused pops), a status code and the
//   empty and full flags after the operation.
//   In an operation, the accept cycle updates the marks and issues the
//   store access, and the next cycle loads the result register from the
//   registered store read. A new request is not taken until the result of
//   the last one has been loaded.
//   Reset sets both marks to minus one (empty) and drops rsp_tvalid; the
//   store contents are not cleared and need no clearing pass.
//   When the receiver stalls, the result is held in the output register and
//   one further request is accepted only in the cycle the result is taken.
// ----------------------------------------------------------------------------
module array_double_ended_queue_top
   import adq_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // cmd[1:0], push_value[33:2], zero pad
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // pop_value[31:0], status[33:32],
                                             // now_empty[34], now_full[35], zero pad
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // Controller
   adq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .req_tready (req_tready),
      .ctrl_cmd   (ctrl_cmd)
   );

   // Datapath
   adq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl_cmd   (ctrl_cmd),
      .dp_status  (dp_status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> rtl/adq_checker.sv
// ----------------------------------------------------------------------------
// Array deque checker
// Port-level assertions on transaction timing and result encoding.
// ----------------------------------------------------------------------------
module adq_checker
   import adq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // One transaction at a time: no accept in the cycle after an accept
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous one in flight");

   // Result valid follows an accept through the load state and the result register
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("result missing two cycles after accept");

   // Refused operations return all ones
   a_refused_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[WORD_W+1:WORD_W] != ST_OK)
      |-> (rsp_tdata[WORD_W-1:0] == '1))
      else $error("refused operation returned a word");

endmodule

bind array_double_ended_queue_top adq_checker u_adq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/sv/array_double_ended_queue_top_test.sv
// ----------------------------------------------------------------------------
// Array double-ended queue testbench
// Drives push and pop operations at both ends of the deque through the req_
// stream and predicts every result with a local copy of the marks and the
// word store. Each rsp_ transaction is checked field by field against the
// oldest predicted result. Both stream sides idle at random, and the receiver
// holds off for a long stretch once so that the block stalls its input.
// ----------------------------------------------------------------------------
module array_double_ended_queue_top_test;
   import adq_pkg::*;

   localparam int unsigned DQ_DEPTH    = DEPTH_DEF;
   localparam int          CYCLE_LIMIT = 300000;
   localparam int          PRINT_LIMIT = 40;

   // Result fields as carried in rsp_tdata
   typedef struct packed {
      logic [WORD_W-1:0] pop_value;
      status_type        status;
      logic              now_empty;
      logic              now_full;
   } deque_result_t;

   // Operation mixes that steer the deque toward different fill levels
   typedef enum logic [1:0] {
      MIX_FILL  = 2'd0,
      MIX_DRAIN = 2'd1,
      MIX_FRONT = 2'd2,
      MIX_EVEN  = 2'd3
   } op_mix_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Predictor state: marks held as offsets (mark + 1)
   logic [4:0]            front_off;
   logic [4:0]            rear_off;
   logic [WORD_W-1:0]     deque_words [DQ_DEPTH];

   deque_result_t         pending_results[$];
   int                    err_count      = 0;
   int                    cycle_count    = 0;
   int                    rsp_hold_req   = 0;
   int                    rsp_stall_left = 0;
   bit                    no_idle        = 1'b0;

   array_double_ended_queue_top #(
      .DEPTH(DQ_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // End the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("array_double_ended_queue_top verification failed");
         $finish;
      end
   end

   // Pick an idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 70) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Compute the result of one operation and advance the predicted state
   function automatic deque_result_t predict_deque(input cmd_type op,
                                                   input logic [WORD_W-1:0] value);
      deque_result_t res;
      logic          was_empty;
      res.pop_value = '1;
      res.status    = ST_OK;
      was_empty     = (front_off == rear_off);
      case (op)
         CMD_PUSH_REAR: begin
            if (rear_off >= DQ_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               deque_words[rear_off[3:0]] = value;
               rear_off = rear_off + 5'd1;
            end
         end
         CMD_PUSH_FRONT: begin
            if (front_off == 0) begin
               res.status = ST_NO_FRONT;
            end else begin
               front_off = front_off - 5'd1;
               deque_words[front_off[3:0]] = value;
            end
         end
         CMD_POP_FRONT: begin
            if (was_empty) begin
               res.status = ST_EMPTY;
            end else begin
               res.pop_value = deque_words[front_off[3:0]];
               front_off = front_off + 5'd1;
            end
         end
         default: begin
            if (was_empty || rear_off == 0) begin
               res.status = ST_EMPTY;
            end else begin
               rear_off = rear_off - 5'd1;
               res.pop_value = deque_words[rear_off[3:0]];
            end
         end
      endcase
      res.now_empty = (front_off == rear_off);
      res.now_full  = (rear_off == DQ_DEPTH);
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      if (err_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
                  cycle_count, field, want, got);
      err_count++;
   endtask

   // Offer one operation and wait for the transaction
   task automatic send_op(input cmd_type op, input logic [WORD_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, value, op};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_deque(op, value));
   endtask

   // Stop offering and wait until every predicted result has arrived
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 19))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Weighted operation choice for each mix
   function automatic cmd_type pick_cmd(input op_mix_t mix);
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (roll < 70) return CMD_PUSH_REAR;
            if (roll < 80) return CMD_PUSH_FRONT;
            if (roll < 90) return CMD_POP_FRONT;
            return CMD_POP_REAR;
         end
         MIX_DRAIN: begin
            if (roll < 20) return CMD_PUSH_REAR;
            if (roll < 30) return CMD_PUSH_FRONT;
            if (roll < 65) return CMD_POP_FRONT;
            return CMD_POP_REAR;
         end
         MIX_FRONT: begin
            if (roll < 15) return CMD_PUSH_REAR;
            if (roll < 55) return CMD_PUSH_FRONT;
            if (roll < 90) return CMD_POP_FRONT;
            return CMD_POP_REAR;
         end
         default: return cmd_type'(roll[1:0]);
      endcase
   endfunction

   // Empty pops, refused pushes at both ends, a full fill with edge words
   task automatic test_directed();
      logic [WORD_W-1:0] edge_words [4];
      edge_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      send_op(CMD_POP_FRONT, 32'h1234_5678);
      send_op(CMD_POP_REAR, 32'h8765_4321);
      send_op(CMD_PUSH_FRONT, 32'hDEAD_BEEF);
      for (int i = 0; i < DQ_DEPTH; i++)
         send_op(CMD_PUSH_REAR, (i < 8) ? edge_words[i[1:0]] : $urandom);
      send_op(CMD_PUSH_REAR, 32'h5555_AAAA);
      send_op(CMD_POP_FRONT, 32'h0);
      send_op(CMD_POP_FRONT, 32'h0);
      send_op(CMD_PUSH_FRONT, 32'hAAAA_5555);
      send_op(CMD_PUSH_FRONT, 32'h8000_0001);
      send_op(CMD_PUSH_FRONT, 32'h7FFF_FFFE);
      send_op(CMD_POP_REAR, 32'h0);
   endtask

   // Random operations in segments, each segment with its own mix
   task automatic test_random_mix(input int count);
      op_mix_t mix;
      int      seg_left;
      seg_left = 0;
      mix      = MIX_EVEN;
      for (int i = 0; i < count; i++) begin
         if (seg_left == 0) begin
            mix      = op_mix_t'($urandom_range(0, 3));
            seg_left = $urandom_range(20, 60);
         end
         seg_left--;
         send_op(pick_cmd(mix), pick_word());
      end
   endtask

   // Back-to-back transactions with no idling on either side
   task automatic test_back_to_back(input int count);
      no_idle = 1'b1;
      test_random_mix(count);
      no_idle = 1'b0;
   endtask

   // Hold the receiver off while the sender keeps offering
   task automatic test_rsp_backpressure();
      rsp_hold_req = 80;
      test_random_mix(12);
      wait_results_drained();
   endtask

   // Drive rsp_tready, with random stalls and a requested long hold
   always @(posedge clock) begin
      if (rsp_hold_req > 0) begin
         rsp_stall_left = rsp_hold_req;
         rsp_hold_req   = 0;
      end else if (rsp_stall_left == 0 && !no_idle && $urandom_range(0, 99) < 15) begin
         rsp_stall_left = pick_gap();
      end
      if (rsp_stall_left > 0) begin
         rsp_stall_left = rsp_stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      deque_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 32'h0, rsp_tdata[31:0]);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.pop_value)
               report_mismatch("pop_value", want.pop_value, rsp_tdata[31:0]);
            if (rsp_tdata[33:32] !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_tdata[33:32]));
            if (rsp_tdata[34] !== want.now_empty)
               report_mismatch("now_empty", 32'(want.now_empty), 32'(rsp_tdata[34]));
            if (rsp_tdata[35] !== want.now_full)
               report_mismatch("now_full", 32'(want.now_full), 32'(rsp_tdata[35]));
         end
      end
   end

   initial begin
      front_off = '0;
      rear_off  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_back_to_back(120);
      test_rsp_backpressure();
      test_random_mix(700);

      // Let the last results arrive, then allow for pipeline latency
      wait_results_drained();
      repeat (10) @(posedge clock);
      if (err_count == 0 && pending_results.size() == 0) begin
         $display("array_double_ended_queue_top verification clean");
      end else begin
         $display("array_double_ended_queue_top verification failed");
      end
      $finish;
   end

endmodule
